FILE: rtl/sba_pkg.sv
// Shared types, constants and helper functions for the slab block allocator.
// Used through scoped names by the controller, datapath, top level and checker; depends on nothing.
`default_nettype none

package sba_pkg;

    localparam int CLASS_COUNT  = 7;
    localparam int REGION_BYTES = 65536;
    localparam int REGION_LOG   = $clog2(REGION_BYTES);
    localparam int MIN_LOG      = 6;
    localparam int LINK_DEPTH   = REGION_BYTES / 32;
    localparam int LINK_W       = $clog2(LINK_DEPTH);
    localparam int CLS_IDX_W    = $clog2(CLASS_COUNT + 1);
    localparam int BATCH_MAX    = 16;
    localparam int LIMIT_MAX    = 32;
    localparam int CNT_MAX      = 63;
    localparam int ADDR_W       = 19;
    localparam int BATCH_W      = 5;
    localparam int LIMIT_W      = 6;
    localparam int CNT_W        = 6;
    localparam int CFG_IDX_W    = 2;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [2:0]        t_cls;

    localparam t_link NULL_IDX      = t_link'(LINK_DEPTH - 1);
    localparam t_cls  CLS_TOO_LARGE = 3'd7;

    typedef enum logic [2:0] {
        ST_HIT,
        ST_REFILL,
        ST_TOO_LARGE,
        ST_EXHAUSTED,
        ST_FREED,
        ST_FLUSHED,
        ST_HOST,
        ST_NULL
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BATCH_SIZE  = 2'd0,
        CFG_CACHE_LIMIT = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic        cmd;
        logic [31:0] req_size;
        logic [31:0] free_addr;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] block_addr;
        t_cls              size_class;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LATCH,
        OP_HIT_ISSUE,
        OP_HIT_DONE,
        OP_REFILL_START,
        OP_FLUSH_START,
        OP_WALK_STEP,
        OP_REFILL_END,
        OP_FLUSH_END,
        OP_PUSH,
        OP_LOAD_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    st_wr;
        t_status st;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic is_free;
        logic too_large;
        logic null_free;
        logic foreign;
        logic cache_hit;
        logic central_empty;
        logic need_flush;
        logic walk_cont;
    } t_dp_sts;

    function automatic int blk_num(input int k);
        return REGION_BYTES >> (MIN_LOG + k);
    endfunction

    function automatic int blk_base(input int k);
        int s;
        s = 0;
        for (int j = 0; j < CLASS_COUNT; j++) begin
            if (j < k) s = s + blk_num(j);
        end
        return s;
    endfunction

    // reset contents of the next-block memory: each block links to its successor in its class, the last one to NULL_IDX
    function automatic t_link init_link(input t_link i);
        t_link r;
        r = NULL_IDX;
        for (int j = 0; j < CLASS_COUNT; j++) begin
            if (int'(i) >= blk_base(j) && int'(i) < blk_base(j) + blk_num(j) - 1)
                r = t_link'(int'(i) + 1);
        end
        return r;
    endfunction

    function automatic t_cls class_of(input logic [31:0] size);
        t_cls r;
        r = CLS_TOO_LARGE;
        for (int j = CLASS_COUNT - 1; j >= 0; j--) begin
            if (size <= (32'(2 ** MIN_LOG) << j)) r = t_cls'(j);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input t_cls k, input t_link idx);
        logic [31:0] a;
        a = (32'(k) << REGION_LOG)
            + ((32'(idx) - 32'(blk_base(int'(k)))) << (MIN_LOG + int'(k)));
        return a[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/slab_block_allocator_unit.sv
// States, accept to result valid: decode, done for too-large, exhausted, null and host items;
// decode, hit, done for a cache hit; decode, push, done for a plain free or a flush with an
// empty cache; decode, walk, done for a central refill; decode, walk, push, done for a
// freed-with-flush. The walk covers m (1..16) blocks, one next-block memory read per cycle.
// Items are handled one at a time; the next item is taken in the cycle after the result is
// registered. Reset (synchronous, active low) starts a pass that links all 2048 entries of
// the next-block memory; inputs stall until it ends, configuration writes still land.
`default_nettype none

module slab_block_allocator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire sba_pkg::t_in_item             i_in_data,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output sba_pkg::t_out_item                 o_out_data,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sba_pkg::LIMIT_W-1:0]   i_cfg_data
);

    sba_pkg::t_dp_cmd dp_cmd;
    sba_pkg::t_dp_sts dp_sts;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequence each item: decode, walk the link memory and push as needed, then hand over
    sba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // hold list heads, cache counts, the link memory and the result register
    sba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (dp_sts),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/sba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`default_nettype none

module sba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/sba_ctrl.sv
// Controller state machine of the slab block allocator.
// Depends on sba_pkg; drives datapath commands and the item handshakes.
`default_nettype none

module sba_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire sba_pkg::t_dp_sts i_sts,
    output sba_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_HIT,
        S_WALK,
        S_PUSH,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_flush, n_flush;
    logic   slot_free;

    assign slot_free  = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd.op    = sba_pkg::OP_NONE;
        o_cmd.st_wr = 1'b0;
        o_cmd.st    = sba_pkg::ST_HIT;
        n_state     = r_state;
        n_flush     = r_flush;
        case (r_state)
            S_INIT: begin
                o_cmd.op = sba_pkg::OP_INIT;
                if (i_sts.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = sba_pkg::OP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.st_wr = 1'b1;
                if (!i_sts.is_free) begin
                    if (i_sts.too_large) begin
                        o_cmd.st = sba_pkg::ST_TOO_LARGE;
                        n_state  = S_DONE;
                    end else if (i_sts.cache_hit) begin
                        o_cmd.st_wr = 1'b0;
                        o_cmd.op    = sba_pkg::OP_HIT_ISSUE;
                        n_state     = S_HIT;
                    end else if (i_sts.central_empty) begin
                        o_cmd.st = sba_pkg::ST_EXHAUSTED;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.st_wr = 1'b0;
                        o_cmd.op    = sba_pkg::OP_REFILL_START;
                        n_flush     = 1'b0;
                        n_state     = S_WALK;
                    end
                end else if (i_sts.null_free) begin
                    o_cmd.st = sba_pkg::ST_NULL;
                    n_state  = S_DONE;
                end else if (i_sts.too_large || i_sts.foreign) begin
                    o_cmd.st = sba_pkg::ST_HOST;
                    n_state  = S_DONE;
                end else if (i_sts.need_flush) begin
                    o_cmd.st = sba_pkg::ST_FLUSHED;
                    if (i_sts.cache_hit) begin
                        o_cmd.op = sba_pkg::OP_FLUSH_START;
                        n_flush  = 1'b1;
                        n_state  = S_WALK;
                    end else begin
                        n_state = S_PUSH;
                    end
                end else begin
                    o_cmd.st = sba_pkg::ST_FREED;
                    n_state  = S_PUSH;
                end
            end
            S_HIT: begin
                o_cmd.op    = sba_pkg::OP_HIT_DONE;
                o_cmd.st_wr = 1'b1;
                o_cmd.st    = sba_pkg::ST_HIT;
                n_state     = S_DONE;
            end
            S_WALK: begin
                if (i_sts.walk_cont) begin
                    o_cmd.op = sba_pkg::OP_WALK_STEP;
                end else if (r_flush) begin
                    o_cmd.op = sba_pkg::OP_FLUSH_END;
                    n_state  = S_PUSH;
                end else begin
                    o_cmd.op    = sba_pkg::OP_REFILL_END;
                    o_cmd.st_wr = 1'b1;
                    o_cmd.st    = sba_pkg::ST_REFILL;
                    n_state     = S_DONE;
                end
            end
            S_PUSH: begin
                o_cmd.op = sba_pkg::OP_PUSH;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.op = sba_pkg::OP_LOAD_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_flush     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
            if (r_state == S_DONE && slot_free) o_out_valid <= 1'b1;
            else if (!i_out_stall)              o_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sba_dp.sv
// Datapath of the slab block allocator: list heads, cache counts, link memory.
// Depends on sba_pkg and sba_ram; executes commands from sba_ctrl.
`default_nettype none

module sba_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sba_pkg::t_dp_cmd                  i_cmd,
    input  wire sba_pkg::t_in_item                 i_in_data,
    input  wire logic                              i_cfg_valid,
    input  wire logic [sba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sba_pkg::LIMIT_W-1:0]       i_cfg_data,
    output sba_pkg::t_dp_sts                       o_sts,
    output sba_pkg::t_out_item                     o_out_data
);

    sba_pkg::t_link              r_central    [sba_pkg::CLASS_COUNT];
    sba_pkg::t_link              r_cache_head [sba_pkg::CLASS_COUNT];
    logic [sba_pkg::CNT_W-1:0]   r_cnt        [sba_pkg::CLASS_COUNT];
    logic [sba_pkg::BATCH_W-1:0] r_batch;
    logic [sba_pkg::LIMIT_W-1:0] r_limit;
    logic                        r_cmd;
    sba_pkg::t_cls               r_k;
    logic [31:0]                 r_fa;
    sba_pkg::t_status            r_st;
    logic [sba_pkg::ADDR_W-1:0]  r_addr;
    sba_pkg::t_link              r_tail, r_start, r_first, r_init_idx;
    logic [sba_pkg::BATCH_W-1:0] r_m;

    logic [sba_pkg::CLS_IDX_W-1:0] ks;
    logic [sba_pkg::BATCH_W-1:0]   eb;
    logic [sba_pkg::LIMIT_W-1:0]   el;
    logic [31:0]                   off;
    sba_pkg::t_link                b, nx, rd_addr, wr_addr, wr_data;
    logic                          wr_en;

    // class index guarded so that the too-large code never indexes the arrays
    assign ks  = (r_k == sba_pkg::CLS_TOO_LARGE) ? '0 : r_k;
    assign eb  = (r_batch == '0) ? sba_pkg::BATCH_W'(1)
               : (r_batch > sba_pkg::BATCH_W'(sba_pkg::BATCH_MAX))
                 ? sba_pkg::BATCH_W'(sba_pkg::BATCH_MAX) : r_batch;
    assign el  = (r_limit == '0) ? sba_pkg::LIMIT_W'(1)
               : (r_limit > sba_pkg::LIMIT_W'(sba_pkg::LIMIT_MAX))
                 ? sba_pkg::LIMIT_W'(sba_pkg::LIMIT_MAX) : r_limit;
    assign off = r_fa & 32'(sba_pkg::REGION_BYTES - 1);
    assign b   = sba_pkg::t_link'(32'(sba_pkg::blk_base(int'(ks)))
                 + (off >> (sba_pkg::MIN_LOG + int'(ks))));

    always_comb begin
        o_sts.init_last     = (r_init_idx == sba_pkg::NULL_IDX);
        o_sts.is_free       = r_cmd;
        o_sts.too_large     = (r_k == sba_pkg::CLS_TOO_LARGE);
        o_sts.null_free     = (r_fa == '0);
        o_sts.foreign       = ((r_fa >> sba_pkg::REGION_LOG) != 32'(r_k));
        o_sts.cache_hit     = (r_cache_head[ks] != sba_pkg::NULL_IDX);
        o_sts.central_empty = (r_central[ks] == sba_pkg::NULL_IDX);
        o_sts.need_flush    = (r_cnt[ks] >= el);
        o_sts.walk_cont     = (r_m < eb) && (nx != sba_pkg::NULL_IDX);
    end

    always_comb begin
        rd_addr = r_tail;
        wr_en   = 1'b0;
        wr_addr = r_tail;
        wr_data = sba_pkg::NULL_IDX;
        case (i_cmd.op)
            sba_pkg::OP_HIT_ISSUE,
            sba_pkg::OP_FLUSH_START:  rd_addr = r_cache_head[ks];
            sba_pkg::OP_REFILL_START: rd_addr = r_central[ks];
            sba_pkg::OP_WALK_STEP:    rd_addr = nx;
            sba_pkg::OP_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_init_idx;
                wr_data = sba_pkg::init_link(r_init_idx);
            end
            sba_pkg::OP_REFILL_END: wr_en = 1'b1;
            sba_pkg::OP_FLUSH_END: begin
                wr_en   = 1'b1;
                wr_data = r_central[ks];
            end
            sba_pkg::OP_PUSH: begin
                wr_en   = 1'b1;
                wr_addr = b;
                wr_data = r_cache_head[ks];
            end
            default: ;
        endcase
    end

    sba_ram #(
        .WIDTH (sba_pkg::LINK_W),
        .DEPTH (sba_pkg::LINK_DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (nx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sba_pkg::CLASS_COUNT; k++) begin
                r_central[k]    <= sba_pkg::t_link'(sba_pkg::blk_base(k));
                r_cache_head[k] <= sba_pkg::NULL_IDX;
                r_cnt[k]        <= '0;
            end
            r_batch    <= sba_pkg::BATCH_W'(sba_pkg::BATCH_MAX);
            r_limit    <= sba_pkg::LIMIT_W'(sba_pkg::LIMIT_MAX);
            r_init_idx <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sba_pkg::CFG_BATCH_SIZE:  r_batch <= i_cfg_data[sba_pkg::BATCH_W-1:0];
                    sba_pkg::CFG_CACHE_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.st_wr) r_st <= i_cmd.st;
            case (i_cmd.op)
                sba_pkg::OP_INIT: r_init_idx <= r_init_idx + 1'b1;
                sba_pkg::OP_LATCH: begin
                    r_cmd  <= i_in_data.cmd;
                    r_k    <= sba_pkg::class_of(i_in_data.req_size);
                    r_fa   <= i_in_data.free_addr;
                    r_addr <= '0;
                end
                sba_pkg::OP_HIT_DONE: begin
                    r_cache_head[ks] <= nx;
                    if (r_cnt[ks] != '0) r_cnt[ks] <= r_cnt[ks] - 1'b1;
                    r_addr <= sba_pkg::addr_of(ks, r_cache_head[ks]);
                end
                sba_pkg::OP_REFILL_START: begin
                    r_tail  <= r_central[ks];
                    r_start <= r_central[ks];
                    r_m     <= sba_pkg::BATCH_W'(1);
                end
                sba_pkg::OP_FLUSH_START: begin
                    r_tail  <= r_cache_head[ks];
                    r_start <= r_cache_head[ks];
                    r_m     <= sba_pkg::BATCH_W'(1);
                end
                sba_pkg::OP_WALK_STEP: begin
                    r_tail <= nx;
                    r_m    <= r_m + 1'b1;
                    if (r_m == sba_pkg::BATCH_W'(1)) r_first <= nx;
                end
                sba_pkg::OP_REFILL_END: begin
                    r_central[ks] <= nx;
                    if (r_m > sba_pkg::BATCH_W'(1)) r_cache_head[ks] <= r_first;
                    r_cnt[ks] <= sba_pkg::CNT_W'(r_m - 1'b1);
                    r_addr    <= sba_pkg::addr_of(ks, r_start);
                end
                sba_pkg::OP_FLUSH_END: begin
                    r_cache_head[ks] <= nx;
                    r_cnt[ks] <= (r_cnt[ks] > sba_pkg::CNT_W'(r_m))
                                 ? r_cnt[ks] - sba_pkg::CNT_W'(r_m) : '0;
                    r_central[ks] <= r_start;
                end
                sba_pkg::OP_PUSH: begin
                    r_cache_head[ks] <= b;
                    if (r_cnt[ks] != sba_pkg::CNT_W'(sba_pkg::CNT_MAX))
                        r_cnt[ks] <= r_cnt[ks] + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result register: payload only, valid lives in the controller
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sba_pkg::OP_LOAD_OUT) begin
            o_out_data.status     <= r_st;
            o_out_data.block_addr <= r_addr;
            o_out_data.size_class <= r_k;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sba_checker.sv
// Port-level assertions for the slab block allocator, bound to the top level.
// Depends on sba_pkg and slab_block_allocator_unit.
`default_nettype none

module sba_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire sba_pkg::t_out_item o_out_data
);

    // link pass follows every reset
    a_init_stall: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != sba_pkg::ST_HIT
         && o_out_data.status != sba_pkg::ST_REFILL) |-> (o_out_data.block_addr == '0))
        else $error("address on a non-allocating result");

    a_too_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == sba_pkg::ST_TOO_LARGE)
        |-> (o_out_data.size_class == sba_pkg::CLS_TOO_LARGE))
        else $error("too-large result with a real class");

endmodule

bind slab_block_allocator_unit sba_checker u_sba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
